// ===== design/rdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// rdlp_pkg
// Shared widths, register indexes, mode codes and types for the rotating
// dual-row LED pattern generator.
// ----------------------------------------------------------------------------
package rdlp_pkg;

    localparam int MAX_WIDTH   = 32;
    localparam int COL_W       = 5;     // column index
    localparam int WIDTH_W     = 6;     // strip width, 1..MAX_WIDTH
    localparam int ELAPSED_W   = 10;
    localparam int ACC_W       = 17;
    localparam int DELAY_W     = 16;
    localparam int COLOR_W     = 24;
    localparam int MODE_W      = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 32;

    localparam logic [ACC_W-1:0]   ACC_MAX       = {ACC_W{1'b1}};
    localparam logic [WIDTH_W-1:0] WIDTH_DEFAULT = WIDTH_W'(MAX_WIDTH);

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_EFFECT_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_COLOR = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DELAY_MS    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIP_WIDTH = 2'd3;

    // Effect mode codes
    localparam logic [MODE_W-1:0] MODE_BLACK      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SOLID      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ROTATE_1   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OPPOSITE_1 = 3'd5;

    // Lit pattern of one frame and the rotation position that follows it
    typedef struct packed {
        logic [MAX_WIDTH-1:0] lit0;
        logic [MAX_WIDTH-1:0] lit1;
        logic [COL_W-1:0]     next_pos;
    } frame_plan_t;

endpackage

// ===== design/rdlp_plan.sv =====
// ----------------------------------------------------------------------------
// rdlp_plan
// Builds the lit masks of both rows for one frame from the effect mode,
// the strip width and the rotation position, and the position after it.
// ----------------------------------------------------------------------------
module rdlp_plan (
    input  logic [rdlp_pkg::MODE_W-1:0]  mode,
    input  logic [rdlp_pkg::WIDTH_W-1:0] width,
    input  logic [rdlp_pkg::COL_W-1:0]   pos,
    output rdlp_pkg::frame_plan_t        plan
);

    // Bring a value below 2*width+1 into 0..width-1
    function automatic logic [rdlp_pkg::COL_W-1:0] wrap_col(
        input logic [rdlp_pkg::WIDTH_W:0] v,
        input logic [rdlp_pkg::WIDTH_W-1:0] w
    );
        logic [rdlp_pkg::WIDTH_W:0] r;
        r = v;
        if (r >= {1'b0, w}) begin
            r = r - {1'b0, w};
        end
        if (r >= {1'b0, w}) begin
            r = r - {1'b0, w};
        end
        return r[rdlp_pkg::COL_W-1:0];
    endfunction

    logic                        opposite;
    logic                        rotating;
    logic [1:0]                  npts;
    logic [rdlp_pkg::COL_W-1:0]  p;
    logic [rdlp_pkg::WIDTH_W:0]  up_val;
    logic [rdlp_pkg::WIDTH_W:0]  dn_val;
    logic [rdlp_pkg::COL_W-1:0]  c0;
    logic [rdlp_pkg::COL_W-1:0]  c1;
    logic [rdlp_pkg::WIDTH_W:0]  p_inc;

    assign rotating = (mode >= rdlp_pkg::MODE_ROTATE_1);
    assign opposite = (mode >= rdlp_pkg::MODE_OPPOSITE_1);
    assign npts     = opposite ? 2'(mode - rdlp_pkg::MODE_OPPOSITE_1 + 3'd1)
                               : 2'(mode - rdlp_pkg::MODE_ROTATE_1 + 3'd1);
    // A stale position beyond the width restarts at column 0
    assign p        = ({1'b0, pos} >= width) ? '0 : pos;
    assign p_inc    = {2'b00, p} + 7'd1;

    // Mark the lit columns of both rows; advance the rotation only in the
    // rotate and opposite modes
    always_comb begin
        plan.lit0     = '0;
        plan.lit1     = '0;
        plan.next_pos = pos;
        up_val        = '0;
        dn_val        = '0;
        c0            = '0;
        c1            = '0;
        if (mode == rdlp_pkg::MODE_SOLID) begin
            for (int i = 0; i < rdlp_pkg::MAX_WIDTH; i++) begin
                plan.lit0[i] = (i < int'(width));
                plan.lit1[i] = (i < int'(width));
            end
        end else if (rotating) begin
            for (int k = 0; k < 3; k++) begin
                up_val = {2'b00, p} + 7'(k);
                dn_val = {width, 1'b0} - {2'b00, p} - 7'(k);
                c0     = wrap_col(up_val, width);
                c1     = opposite ? wrap_col(dn_val, width) : c0;
                if (k < int'(npts)) begin
                    plan.lit0[c0] = 1'b1;
                    plan.lit1[c1] = 1'b1;
                end
            end
            plan.next_pos = (p_inc >= {1'b0, width}) ? '0 : p_inc[rdlp_pkg::COL_W-1:0];
        end
    end

endmodule

// ===== design/rotating_dual_row_led_pattern.sv =====
// ----------------------------------------------------------------------------
// rotating_dual_row_led_pattern
// Accumulates elapsed milliseconds and, once the delay is reached, renders
// a two-row frame of lit and dark pixels, one pixel beat per cycle when not stalled.
// ----------------------------------------------------------------------------
//  channel  | direction | beat contents
//  s_       | in        | elapsed_ms, one tick of time
//  m_       | out       | row, column, color; tlast on the final pixel
//  cfg_     | in        | register write, index and data
//
//  An item that renders nothing does not hold off input; one may enter every
//  cycle while no frame is active. A rendering item starts a frame of 2*W
//  pixel beats, one per cycle unless the output stalls, set by the pixel
//  counter; input is held off until the last pixel is loaded into the output
//  register. Output stalls hold the pixel counter and the output register.
//  Reset is synchronous and active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
module rotating_dual_row_led_pattern (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wen,
    input  logic [rdlp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rdlp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input ticks
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rdlp_pkg::S_TDATA_W-1:0]    s_tdata,   // [9:0] elapsed_ms
    // pixel beats
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rdlp_pkg::M_TDATA_W-1:0]    m_tdata,   // [0] row, [5:1] column,
                                                         // [29:6] color
    output logic                              m_tlast
);

    // Configuration registers
    logic [rdlp_pkg::MODE_W-1:0]    mode_reg;
    logic [rdlp_pkg::COLOR_W-1:0]   color_reg;
    logic [rdlp_pkg::DELAY_W-1:0]   delay_reg;
    logic [rdlp_pkg::WIDTH_W-1:0]   width_reg;

    // Running state
    logic [rdlp_pkg::ACC_W-1:0]     acc_reg;
    logic [rdlp_pkg::ACC_W-1:0]     acc_next;
    logic [rdlp_pkg::COL_W-1:0]     pos_reg;

    // Frame in progress
    logic                           active_reg;
    logic                           row_reg;
    logic [rdlp_pkg::COL_W-1:0]     col_reg;
    logic [rdlp_pkg::WIDTH_W-1:0]   fwidth_reg;
    logic [rdlp_pkg::MAX_WIDTH-1:0] lit0_reg;
    logic [rdlp_pkg::MAX_WIDTH-1:0] lit1_reg;

    // Output register
    logic                           m_valid_reg;
    logic [rdlp_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                           m_last_reg;

    logic                           in_fire;
    logic                           render;
    logic [rdlp_pkg::ACC_W:0]       acc_sum;
    logic [rdlp_pkg::ACC_W-1:0]     acc_sat;
    logic [rdlp_pkg::WIDTH_W-1:0]   wr_width;
    rdlp_pkg::frame_plan_t          plan;
    logic                           out_load;
    logic                           col_end;
    logic                           pix_on;
    logic [rdlp_pkg::COLOR_W-1:0]   pix_color;

    assign s_tready = !active_reg;
    assign in_fire  = s_tvalid && s_tready;

    // Saturating accumulate and delay check
    assign acc_sum  = {1'b0, acc_reg} + (rdlp_pkg::ACC_W + 1)'(s_tdata[rdlp_pkg::ELAPSED_W-1:0]);
    assign acc_sat  = acc_sum[rdlp_pkg::ACC_W] ? rdlp_pkg::ACC_MAX
                                               : acc_sum[rdlp_pkg::ACC_W-1:0];
    assign render   = (acc_sat >= rdlp_pkg::ACC_W'(delay_reg));

    always_comb begin
        acc_next = acc_reg;
        if (in_fire) begin
            acc_next = render ? '0 : acc_sat;
        end
    end

    // Clamp a written width into 1..MAX_WIDTH
    always_comb begin
        wr_width = cfg_wdata[rdlp_pkg::WIDTH_W-1:0];
        if (wr_width == '0) begin
            wr_width = rdlp_pkg::WIDTH_W'(1);
        end else if (wr_width > rdlp_pkg::WIDTH_DEFAULT) begin
            wr_width = rdlp_pkg::WIDTH_DEFAULT;
        end
    end

    rdlp_plan u_plan (
        .mode  (mode_reg),
        .width (width_reg),
        .pos   (pos_reg),
        .plan  (plan)
    );

    // Current pixel of the frame
    assign out_load  = active_reg && (!m_valid_reg || m_tready);
    assign col_end   = ({1'b0, col_reg} == (fwidth_reg - rdlp_pkg::WIDTH_W'(1)));
    assign pix_on    = row_reg ? lit1_reg[col_reg] : lit0_reg[col_reg];
    assign pix_color = pix_on ? color_reg : '0;

    // Configuration writes and running state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= rdlp_pkg::MODE_BLACK;
            color_reg <= '0;
            delay_reg <= '0;
            width_reg <= rdlp_pkg::WIDTH_DEFAULT;
            acc_reg   <= '0;
            pos_reg   <= '0;
        end else begin
            acc_reg <= acc_next;
            if (in_fire && render) begin
                pos_reg <= plan.next_pos;
            end
            if (cfg_wen) begin
                case (cfg_index)
                    rdlp_pkg::REG_EFFECT_MODE: mode_reg  <= cfg_wdata[rdlp_pkg::MODE_W-1:0];
                    rdlp_pkg::REG_PIXEL_COLOR: color_reg <= cfg_wdata[rdlp_pkg::COLOR_W-1:0];
                    rdlp_pkg::REG_DELAY_MS:    delay_reg <= cfg_wdata[rdlp_pkg::DELAY_W-1:0];
                    rdlp_pkg::REG_STRIP_WIDTH: begin
                        width_reg <= wr_width;
                        pos_reg   <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Frame sequencer: start on a rendering beat, walk row 0 then row 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            row_reg    <= 1'b0;
            col_reg    <= '0;
        end else if (in_fire && render) begin
            active_reg <= 1'b1;
            row_reg    <= 1'b0;
            col_reg    <= '0;
        end else if (out_load) begin
            if (col_end) begin
                col_reg <= '0;
                row_reg <= 1'b1;
                if (row_reg) begin
                    active_reg <= 1'b0;
                end
            end else begin
                col_reg <= col_reg + rdlp_pkg::COL_W'(1);
            end
        end
    end

    // Latch the frame pattern
    always_ff @(posedge aclk) begin
        if (in_fire && render) begin
            fwidth_reg <= width_reg;
            lit0_reg   <= plan.lit0;
            lit1_reg   <= plan.lit1;
        end
    end

    // Output register: load a pixel when empty or being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {2'b00, pix_color, col_reg, row_reg};
            m_last_reg <= row_reg && col_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== design/rdlp_checker.sv =====
// ----------------------------------------------------------------------------
// rdlp_checker
// Port-level checks of the pixel stream and its handshakes.
// ----------------------------------------------------------------------------
module rdlp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rdlp_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    // Hold a stalled pixel beat
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("pixel beat dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("pixel beat changed while stalled");

    // The frame always ends on the lower row
    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[0])
        else $error("frame end on upper row");

    // No new tick is taken while a frame is still being walked
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a frame");

endmodule

bind rotating_dual_row_led_pattern rdlp_checker u_rdlp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/rotating_dual_row_led_pattern_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotating_dual_row_led_pattern_tb
// Drives elapsed-millisecond ticks into the pattern generator and checks every
// pixel beat against a cycle-free model of the accumulator, the rotation
// position and the lit columns of both rows. Runs a directed set of modes,
// widths and delays, then random phases under varying back-pressure.
// ----------------------------------------------------------------------------
module rotating_dual_row_led_pattern_tb;
    import rdlp_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TAIL_CYCLES    = 80;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PRINT_LIMIT    = 100;
    localparam int RANDOM_PHASES  = 8;

    localparam logic [MODE_W-1:0] MODE_ROTATE_2   = MODE_ROTATE_1 + 3'd1;
    localparam logic [MODE_W-1:0] MODE_ROTATE_3   = MODE_ROTATE_1 + 3'd2;
    localparam logic [MODE_W-1:0] MODE_OPPOSITE_2 = MODE_OPPOSITE_1 + 3'd1;
    localparam logic [MODE_W-1:0] MODE_OPPOSITE_3 = MODE_OPPOSITE_1 + 3'd2;

    typedef struct packed {
        logic               row;
        logic [COL_W-1:0]   column;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wen   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // [9:0] elapsed_ms
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // [0] row, [5:1] column, [29:6] color
    logic                   m_tlast;

    // Model copy of the registers and the pattern state
    logic [MODE_W-1:0]    mode_reg  = MODE_BLACK;
    logic [COLOR_W-1:0]   color_reg = '0;
    logic [DELAY_W-1:0]   delay_reg = '0;
    int unsigned          width_reg = MAX_WIDTH;
    logic [ACC_W-1:0]     acc_ms    = '0;
    logic [COL_W-1:0]     rot_pos   = '0;

    logic [ELAPSED_W-1:0] pending_ticks[$];
    pixel_t               expected_pixels[$];

    int ticks_queued     = 0;
    int ticks_accepted   = 0;
    int frames_predicted = 0;
    int pixels_checked   = 0;
    int reg_writes       = 0;
    int err_count        = 0;
    int stall_cycles     = 0;
    int tx_idle_pct      = 0;
    int rx_stall_pct     = 0;
    int rx_hold_reqs     = 0;
    int rx_hold_seen     = 0;
    int rx_hold_left     = 0;

    rotating_dual_row_led_pattern u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Free-running clock
    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Accumulate one tick and, when the delay is reached, queue the frame
    function automatic void advance_pattern(input logic [ELAPSED_W-1:0] elapsed);
        int unsigned sum;
        int unsigned p;
        int unsigned npts;
        int unsigned c0;
        int unsigned c1;
        bit          opposite;
        logic [MAX_WIDTH-1:0] lit0;
        logic [MAX_WIDTH-1:0] lit1;
        pixel_t px;
        sum = 32'(acc_ms) + 32'(elapsed);
        if (sum > 32'(ACC_MAX)) sum = 32'(ACC_MAX);
        if (sum < 32'(delay_reg)) begin
            acc_ms = ACC_W'(sum);
            return;
        end
        acc_ms = '0;
        lit0 = '0;
        lit1 = '0;
        if (mode_reg == MODE_SOLID) begin
            lit0 = '1;
            lit1 = '1;
        end else if (mode_reg >= MODE_ROTATE_1) begin
            opposite = (mode_reg >= MODE_OPPOSITE_1);
            npts = opposite ? 32'(mode_reg - MODE_OPPOSITE_1) + 1
                            : 32'(mode_reg - MODE_ROTATE_1) + 1;
            p = 32'(rot_pos);
            if (p >= width_reg) p = 0;
            for (int k = 0; k < npts; k++) begin
                c0 = (p + k) % width_reg;
                // mirror on the lower row, kept non-negative by adding 2W
                c1 = opposite ? (2 * width_reg - p - k) % width_reg : c0;
                lit0[c0] = 1'b1;
                lit1[c1] = 1'b1;
            end
            p++;
            if (p >= width_reg) p = 0;
            rot_pos = COL_W'(p);
        end
        frames_predicted++;
        for (int r = 0; r < 2; r++) begin
            for (int col = 0; col < width_reg; col++) begin
                px.row    = r[0];
                px.column = COL_W'(col);
                px.color  = ((r == 0) ? lit0[col] : lit1[col]) ? color_reg : '0;
                px.last   = (r == 1) && (col == width_reg - 1);
                expected_pixels.push_back(px);
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (err_count < PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    // Wait until every tick is in and every pixel is out, then let the block settle
    task automatic wait_drain();
        do @(negedge aclk);
        while (ticks_accepted != ticks_queued || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Register write, only once the block has gone idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        logic [WIDTH_W-1:0] w;
        wait_drain();
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_EFFECT_MODE: mode_reg  = val[MODE_W-1:0];
            REG_PIXEL_COLOR: color_reg = val[COLOR_W-1:0];
            REG_DELAY_MS:    delay_reg = val[DELAY_W-1:0];
            REG_STRIP_WIDTH: begin
                w = val[WIDTH_W-1:0];
                width_reg = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : 32'(w);
                rot_pos = '0;
            end
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic queue_tick(input int unsigned v);
        pending_ticks.push_back(ELAPSED_W'(v));
        ticks_queued++;
    endtask

    function automatic int unsigned random_tick();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 0;
        if (sel == 1) return (1 << ELAPSED_W) - 1;
        return $urandom_range(0, (1 << ELAPSED_W) - 1);
    endfunction

    // Tick driver: hold a beat until taken, then offer the next or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_pattern(s_tdata[ELAPSED_W-1:0]);
                ticks_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_ticks.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'(pending_ticks.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Pixel receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (rx_hold_seen != rx_hold_reqs) begin
            rx_hold_seen = rx_hold_reqs;
            rx_hold_left = RX_HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Pixel monitor: compare each beat with the oldest predicted pixel
    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected pixel beat", m_tdata, 0);
            end else begin
                want = expected_pixels.pop_front();
                if (m_tdata[0] !== want.row)
                    report_mismatch("row", 32'(m_tdata[0]), 32'(want.row));
                if (m_tdata[5:1] !== want.column)
                    report_mismatch("column", 32'(m_tdata[5:1]), 32'(want.column));
                if (m_tdata[29:6] !== want.color)
                    report_mismatch("color", 32'(m_tdata[29:6]), 32'(want.color));
                if (m_tlast !== want.last)
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
            end
            pixels_checked++;
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a beat", stall_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int n_items;
        int sel;
        int base;
        logic [CFG_DATA_W-1:0] wval;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset defaults give black frames at full width
        queue_tick(0);
        queue_tick(1023);

        // Solid white, then the narrowest strip from a zero width write
        write_reg(REG_EFFECT_MODE, CFG_DATA_W'(MODE_SOLID));
        write_reg(REG_PIXEL_COLOR, 24'hFFFFFF);
        queue_tick(512);
        write_reg(REG_STRIP_WIDTH, 24'd0);
        queue_tick(1);

        // Three rotating points on five columns, then the mirrored variant wraps
        write_reg(REG_STRIP_WIDTH, 24'd5);
        write_reg(REG_EFFECT_MODE, CFG_DATA_W'(MODE_ROTATE_3));
        write_reg(REG_PIXEL_COLOR, 24'hA55A3C);
        repeat (3) queue_tick(7);
        write_reg(REG_EFFECT_MODE, CFG_DATA_W'(MODE_OPPOSITE_3));
        repeat (3) queue_tick(7);

        // Points overlap when the strip is narrower than the point count
        write_reg(REG_STRIP_WIDTH, 24'd1);
        write_reg(REG_EFFECT_MODE, CFG_DATA_W'(MODE_ROTATE_3));
        queue_tick(3);
        write_reg(REG_EFFECT_MODE, CFG_DATA_W'(MODE_OPPOSITE_3));
        queue_tick(3);
        write_reg(REG_STRIP_WIDTH, 24'd2);
        write_reg(REG_EFFECT_MODE, CFG_DATA_W'(MODE_OPPOSITE_2));
        repeat (2) queue_tick(3);
        write_reg(REG_EFFECT_MODE, CFG_DATA_W'(MODE_ROTATE_2));
        repeat (2) queue_tick(3);

        // Oversized width clamps; solid mode leaves the rotation where it is
        write_reg(REG_STRIP_WIDTH, 24'hFFFFFF);
        write_reg(REG_EFFECT_MODE, CFG_DATA_W'(MODE_ROTATE_1));
        repeat (2) queue_tick(9);
        write_reg(REG_EFFECT_MODE, CFG_DATA_W'(MODE_SOLID));
        queue_tick(9);
        write_reg(REG_EFFECT_MODE, CFG_DATA_W'(MODE_OPPOSITE_1));
        queue_tick(9);

        // Delay threshold: excess dropped on render, exact hit renders
        write_reg(REG_STRIP_WIDTH, 24'd4);
        write_reg(REG_DELAY_MS, 24'd1000);
        queue_tick(1023);
        queue_tick(500);
        queue_tick(499);
        queue_tick(1);
        queue_tick(999);
        queue_tick(0);
        queue_tick(1);

        // Random phases, each with its own settings and idle pattern
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drain();
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
                default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
            endcase
            write_reg(REG_EFFECT_MODE, CFG_DATA_W'($urandom));
            write_reg(REG_PIXEL_COLOR, CFG_DATA_W'($urandom));

            sel = $urandom_range(0, 9);
            if (sel == 0)      wval = 24'd0;
            else if (sel == 1) wval = 24'd1;
            else if (sel == 2) wval = 24'd32;
            else if (sel == 3) wval = 24'($urandom_range(33, 63));
            else               wval = 24'($urandom_range(1, 12));
            wval[CFG_DATA_W-1:WIDTH_W] = (CFG_DATA_W-WIDTH_W)'($urandom);
            if (ph == 2) wval = 24'd32;
            write_reg(REG_STRIP_WIDTH, wval);

            sel = $urandom_range(0, 3);
            if (sel == 0)      wval = 24'd0;
            else if (sel == 1) wval = 24'($urandom_range(1, 1023));
            else if (sel == 2) wval = 24'($urandom_range(1024, 3000));
            else               wval = 24'($urandom_range(0, 400));
            if (ph == 2) wval = 24'd0;
            if (ph == RANDOM_PHASES - 1) wval = 24'hFFFF;
            wval[CFG_DATA_W-1:DELAY_W] = 8'($urandom);
            write_reg(REG_DELAY_MS, wval);

            if (ph == 2) begin
                // Long receiver hold-off while ticks keep coming
                base = ticks_accepted;
                n_items = 12;
                repeat (n_items) queue_tick(random_tick());
                do @(negedge aclk); while (ticks_accepted < base + 2);
                rx_hold_reqs++;
            end else if (ph == 5) begin
                // Sender waits for the last pixel before sending the second half
                repeat (13) queue_tick(random_tick());
                wait_drain();
                repeat (13) queue_tick(random_tick());
            end else if (ph == RANDOM_PHASES - 1) begin
                // Longest delay: a frame only after many full ticks
                repeat (66) queue_tick(($urandom_range(0, 3) != 0) ? 1023 : random_tick());
            end else begin
                repeat (26) queue_tick(random_tick());
            end
        end

        // Let the last frame out and watch for stray beats
        wait_drain();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("Covered %0d ticks over %0d register writes: %0d frames, %0d pixel beats.",
                 ticks_accepted, reg_writes, frames_predicted, pixels_checked);
        $display("All eight modes, widths from 1 to 32 and delays up to the maximum ran.");
        if (err_count == 0 && expected_pixels.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d pixels still waiting", err_count,
                     expected_pixels.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
